[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the float XOR encoder top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, disabled while reset is asserted (active-low reset).
`define FXSE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define FXSE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FXSE_ASSERT(label, clk, rstn, prop, msg)
`define FXSE_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[hdl/fxse_pkg.sv]
// ----------------------------------------------------------------------------
// fxse_pkg
// Widths, header codes and shared types of the float XOR stream encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fxse_pkg;

    localparam int WORD_BITS   = 64;
    localparam int HDR_CODE_W  = 11;
    localparam int HDR_LEN_W   = 4;
    localparam int PAY_LEN_W   = 7;
    localparam int LEAD_W      = 3;
    localparam int LEAD_REG_W  = 4;
    localparam int TAIL_W      = 7;

    localparam logic [LEAD_W-1:0]     LEAD_CAP      = 3'd7;
    localparam logic [LEAD_REG_W-1:0] LEAD_RESET    = 4'd8;
    localparam logic [PAY_LEN_W-1:0]  SHORT_LEN_MAX = 7'd16;
    localparam logic [PAY_LEN_W-1:0]  FULL_LEN      = 7'd64;

    localparam logic [1:0] HDR_TAG_SHORT = 2'b10;
    localparam logic [1:0] HDR_TAG_LONG  = 2'b11;

    localparam logic [HDR_CODE_W-1:0] HDR_CODE_NONE  = 11'd0;
    localparam logic [HDR_CODE_W-1:0] HDR_CODE_ZERO  = 11'd1;
    localparam logic [HDR_CODE_W-1:0] HDR_CODE_REUSE = 11'd0;

    localparam logic [HDR_LEN_W-1:0] HDR_LEN_RAW   = 4'd0;
    localparam logic [HDR_LEN_W-1:0] HDR_LEN_CTRL  = 4'd2;
    localparam logic [HDR_LEN_W-1:0] HDR_LEN_SHORT = 4'd9;
    localparam logic [HDR_LEN_W-1:0] HDR_LEN_LONG  = 4'd11;

    typedef struct packed {
        logic [HDR_CODE_W-1:0] header_code;
        logic [HDR_LEN_W-1:0]  header_len;
        logic [WORD_BITS-1:0]  payload;
        logic [PAY_LEN_W-1:0]  payload_len;
    } fxse_result_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  last_word;
        logic [LEAD_REG_W-1:0] last_lead;
        logic [TAIL_W-1:0]     last_tail;
    } fxse_state_t;

endpackage

`default_nettype wire

[hdl/float_xor_stream_encoder.sv]
// ----------------------------------------------------------------------------
// float_xor_stream_encoder
// Streaming XOR encoder for IEEE double bit patterns, one word per cycle when the output is not stalled.
// ----------------------------------------------------------------------------
// Takes one 64-bit word per cycle while the output is not stalled and returns
// one header/payload word per input word. An accepted word goes into the input
// register, then through the combinational XOR, the leading/trailing zero
// counts and the payload shifter into the result register, which also updates
// the stored previous word, lead and tail. The first word after reset goes out
// raw with a 64-bit payload and no header bits. s_ready follows m_ready
// combinationally when both internal stages are occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module float_xor_stream_encoder (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output      logic                                s_ready,
    input  wire logic [fxse_pkg::WORD_BITS-1:0]      s_word_in,

    output      logic                                m_valid,
    input  wire logic                                m_ready,
    output      logic [fxse_pkg::HDR_CODE_W-1:0]     m_header_code,
    output      logic [fxse_pkg::HDR_LEN_W-1:0]      m_header_len,
    output      logic [fxse_pkg::WORD_BITS-1:0]      m_payload,
    output      logic [fxse_pkg::PAY_LEN_W-1:0]      m_payload_len
);
    import fxse_pkg::*;

    logic                 in_valid_reg;
    logic [WORD_BITS-1:0] in_word_reg;
    logic                 first_pending_reg;
    fxse_state_t          state_reg;
    fxse_state_t          state_next;
    logic                 out_valid_reg;
    fxse_result_t         out_res_reg;
    fxse_result_t         res_next;

    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    fxse_encode u_encode (
        .first_word (first_pending_reg),
        .word       (in_word_reg),
        .state_cur  (state_reg),
        .result     (res_next),
        .state_next (state_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word_in;
        end
    end

    // stored history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pending_reg   <= 1'b1;
            state_reg.last_word <= '0;
            state_reg.last_lead <= LEAD_RESET;
            state_reg.last_tail <= '0;
        end else if (advance) begin
            first_pending_reg <= 1'b0;
            state_reg         <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_header_code = out_res_reg.header_code;
    assign m_header_len  = out_res_reg.header_len;
    assign m_payload     = out_res_reg.payload;
    assign m_payload_len = out_res_reg.payload_len;

    `FXSE_ASSERT(a_first_raw, aclk, aresetn, (advance && first_pending_reg) |=> (m_header_len == HDR_LEN_RAW && m_payload_len == FULL_LEN), "first word not emitted raw")
    `FXSE_ASSERT(a_first_once, aclk, aresetn, !first_pending_reg |=> !first_pending_reg, "first-word flag set again")
    `FXSE_ASSERT(a_hdr_len, aclk, aresetn, m_valid |-> (m_header_len == HDR_LEN_RAW || m_header_len == HDR_LEN_CTRL || m_header_len == HDR_LEN_SHORT || m_header_len == HDR_LEN_LONG), "illegal header length")
    `FXSE_ASSERT(a_zero_empty, aclk, aresetn, (m_valid && m_header_len == HDR_LEN_CTRL && m_header_code == HDR_CODE_ZERO) |-> (m_payload_len == '0), "zero XOR carries payload")
    `FXSE_ASSERT_ALWAYS(a_stall_full, aclk, !s_ready |-> (in_valid_reg && out_valid_reg), "input stalled with a free stage")

endmodule

`default_nettype wire

[hdl/fxse_encode.sv]
// ----------------------------------------------------------------------------
// fxse_encode
// XOR against the previous word, zero counts, header build and payload shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fxse_encode (
    input  wire logic                               first_word,
    input  wire logic [fxse_pkg::WORD_BITS-1:0]     word,
    input  wire fxse_pkg::fxse_state_t              state_cur,
    output fxse_pkg::fxse_result_t                  result,
    output fxse_pkg::fxse_state_t                   state_next
);
    import fxse_pkg::*;

    // Leading zeros capped at LEAD_CAP: only the top bits matter.
    function automatic logic [LEAD_W-1:0] lead_count(input logic [WORD_BITS-1:0] v);
        logic [LEAD_W-1:0] cnt;
        cnt = LEAD_CAP;
        for (int i = int'(LEAD_CAP) - 1; i >= 0; i--) begin
            if (v[WORD_BITS-1-i]) begin
                cnt = LEAD_W'(i);
            end
        end
        return cnt;
    endfunction

    // Trailing zeros by binary search, 64 for a zero word.
    function automatic logic [TAIL_W-1:0] tail_count(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] rem;
        logic [TAIL_W-1:0]    cnt;
        rem = v;
        cnt = '0;
        if (v == '0) begin
            cnt = FULL_LEN;
        end else begin
            for (int i = $clog2(WORD_BITS) - 1; i >= 0; i--) begin
                if ((rem & ((WORD_BITS'(1) << (1 << i)) - WORD_BITS'(1))) == '0) begin
                    cnt = cnt | TAIL_W'(1 << i);
                    rem = rem >> (1 << i);
                end
            end
        end
        return cnt;
    endfunction

    logic [WORD_BITS-1:0] xor_word;
    logic [LEAD_W-1:0]    lead;
    logic [TAIL_W-1:0]    tail;
    logic [PAY_LEN_W-1:0] new_len;
    logic [PAY_LEN_W-1:0] new_len_m1;
    logic [PAY_LEN_W-1:0] reuse_len;
    logic                 reuse;

    always_comb begin
        xor_word   = word ^ state_cur.last_word;
        lead       = lead_count(xor_word);
        tail       = tail_count(xor_word);
        new_len    = FULL_LEN - {{(PAY_LEN_W-LEAD_W){1'b0}}, lead} - tail;
        new_len_m1 = new_len - PAY_LEN_W'(1);
        reuse_len  = FULL_LEN - {{(PAY_LEN_W-LEAD_REG_W){1'b0}}, state_cur.last_lead}
                     - state_cur.last_tail;
        reuse      = ({1'b0, lead} == state_cur.last_lead) && (tail >= state_cur.last_tail);

        result     = '0;
        state_next = state_cur;

        if (first_word) begin
            result.header_code = HDR_CODE_NONE;
            result.header_len  = HDR_LEN_RAW;
            result.payload     = word;
            result.payload_len = FULL_LEN;
            state_next.last_word = word;
        end else begin
            state_next.last_word = word;
            state_next.last_lead = {1'b0, lead};
            state_next.last_tail = tail;
            if (xor_word == '0) begin
                result.header_code = HDR_CODE_ZERO;
                result.header_len  = HDR_LEN_CTRL;
            end else if (reuse) begin
                // stored tail is below 64 whenever the XOR is nonzero and reuse holds
                result.header_code = HDR_CODE_REUSE;
                result.header_len  = HDR_LEN_CTRL;
                result.payload     = xor_word >> state_cur.last_tail[$clog2(WORD_BITS)-1:0];
                result.payload_len = reuse_len;
            end else begin
                if (new_len <= SHORT_LEN_MAX) begin
                    result.header_code = {2'b00, HDR_TAG_SHORT, lead, new_len_m1[3:0]};
                    result.header_len  = HDR_LEN_SHORT;
                end else begin
                    result.header_code = {HDR_TAG_LONG, lead, new_len_m1[5:0]};
                    result.header_len  = HDR_LEN_LONG;
                end
                result.payload     = xor_word >> tail[$clog2(WORD_BITS)-1:0];
                result.payload_len = new_len;
            end
        end
    end

endmodule

`default_nettype wire

[dv/float_xor_stream_encoder_tb.sv]
// ----------------------------------------------------------------------------
// float_xor_stream_encoder_tb
// Self-checking bench for the XOR stream encoder: each accepted word is run
// through a local encoder model and the result is checked against the DUT
// output in order. A directed run covers the header forms and window edges.
// Randomized streams of windowed deltas, with some raw noise words, follow
// under several sender and receiver throttling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module float_xor_stream_encoder_tb;
    import fxse_pkg::*;

    localparam int RANDOM_PER_PHASE = 500;
    localparam int WATCHDOG_LIMIT   = 2000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [WORD_BITS-1:0]  s_word_in;
    logic                  m_valid;
    logic                  m_ready;
    logic [HDR_CODE_W-1:0] m_header_code;
    logic [HDR_LEN_W-1:0]  m_header_len;
    logic [WORD_BITS-1:0]  m_payload;
    logic [PAY_LEN_W-1:0]  m_payload_len;

    float_xor_stream_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word_in     (s_word_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_header_code (m_header_code),
        .m_header_len  (m_header_len),
        .m_payload     (m_payload),
        .m_payload_len (m_payload_len)
    );

    logic [WORD_BITS-1:0] word_q[$];
    fxse_result_t         encoded_q[$];
    fxse_result_t         want;

    // encoder model state
    logic [WORD_BITS-1:0]  prev_word  = '0;
    logic [LEAD_REG_W-1:0] prev_lead  = LEAD_RESET;
    logic [TAIL_W-1:0]     prev_tail  = '0;
    logic                  first_word_due = 1'b1;

    // stimulus-side view of the stream
    logic [WORD_BITS-1:0] gen_prev = '0;
    logic                 gen_started = 1'b0;
    int                   gen_lead = 8;
    int                   gen_tail = 0;

    logic in_taken;
    int   idle_pct;
    int   stall_pct;
    int   err_count = 0;
    int   idle_cycles = 0;
    int   phase;
    int   n;
    int   idle_tab[4]  = '{0, 45, 0, 26};
    int   stall_tab[4] = '{0, 0, 45, 26};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int lead_zeros(logic [WORD_BITS-1:0] v);
        int k;
        k = 0;
        while (k < WORD_BITS && !v[WORD_BITS-1-k]) k++;
        return k;
    endfunction

    function automatic int trail_zeros(logic [WORD_BITS-1:0] v);
        int k;
        k = 0;
        while (k < WORD_BITS && !v[k]) k++;
        return k;
    endfunction

    function automatic logic [WORD_BITS-1:0] window_bits(logic [WORD_BITS-1:0] v,
                                                         int sh, int len);
        logic [WORD_BITS-1:0] m;
        m = (len >= WORD_BITS) ? {WORD_BITS{1'b1}} : ((64'd1 << len) - 64'd1);
        return ((sh >= WORD_BITS) ? '0 : (v >> sh)) & m;
    endfunction

    function automatic fxse_result_t encode_word(logic [WORD_BITS-1:0] w);
        fxse_result_t r;
        logic [WORD_BITS-1:0] x;
        int lead;
        int tail;
        int wlen;
        r = '0;
        if (first_word_due) begin
            r.header_code = HDR_CODE_NONE;
            r.header_len  = HDR_LEN_RAW;
            r.payload     = w;
            r.payload_len = FULL_LEN;
            first_word_due = 1'b0;
            prev_word = w;
        end else begin
            x    = w ^ prev_word;
            lead = lead_zeros(x);
            tail = trail_zeros(x);
            if (lead > LEAD_CAP) lead = LEAD_CAP;
            if (x == '0) begin
                r.header_code = HDR_CODE_ZERO;
                r.header_len  = HDR_LEN_CTRL;
            end else if (lead == prev_lead && tail >= prev_tail) begin
                wlen = WORD_BITS - prev_lead - prev_tail;
                if (wlen < 0) wlen = 0;
                r.header_code = HDR_CODE_REUSE;
                r.header_len  = HDR_LEN_CTRL;
                r.payload     = window_bits(x, prev_tail, wlen);
                r.payload_len = PAY_LEN_W'(wlen);
            end else begin
                wlen = WORD_BITS - lead - tail;
                if (wlen <= SHORT_LEN_MAX) begin
                    r.header_code = {2'b00, HDR_TAG_SHORT, 3'(lead), 4'(wlen - 1)};
                    r.header_len  = HDR_LEN_SHORT;
                end else begin
                    r.header_code = {HDR_TAG_LONG, 3'(lead), 6'(wlen - 1)};
                    r.header_len  = HDR_LEN_LONG;
                end
                r.payload     = window_bits(x, tail, wlen);
                r.payload_len = PAY_LEN_W'(wlen);
            end
            prev_lead = LEAD_REG_W'(lead);
            prev_tail = TAIL_W'(tail);
            prev_word = w;
        end
        return r;
    endfunction

    function automatic void push_word(logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] x;
        x = w ^ gen_prev;
        if (gen_started) begin
            gen_lead = (lead_zeros(x) > 7) ? 7 : lead_zeros(x);
            gen_tail = trail_zeros(x);
        end
        gen_started = 1'b1;
        gen_prev = w;
        word_q.push_back(w);
    endfunction

    // nonzero delta with exactly lz leading and tz trailing zeros
    function automatic logic [WORD_BITS-1:0] window_delta(int lz, int tz);
        logic [WORD_BITS-1:0] v;
        v = {$urandom, $urandom};
        v = (v << tz) & ({WORD_BITS{1'b1}} >> lz);
        v[WORD_BITS-1-lz] = 1'b1;
        v[tz] = 1'b1;
        return v;
    endfunction

    function automatic logic [WORD_BITS-1:0] random_delta();
        int pick;
        int lz;
        int tz;
        int wl;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 40 && gen_lead <= 7 && gen_tail <= 63 - gen_lead) begin
            lz = (gen_lead < 7) ? gen_lead : $urandom_range(63 - gen_tail, 7);
            tz = ($urandom_range(2) == 0) ? gen_tail : $urandom_range(63 - lz, gen_tail);
            return window_delta(lz, tz);
        end
        lz = ($urandom_range(9) == 0) ? $urandom_range(63, 8) : $urandom_range(7, 0);
        if (pick < 65 && lz <= 7) begin
            wl = $urandom_range(16, 1);
            tz = WORD_BITS - lz - wl;
        end else begin
            tz = $urandom_range(63 - lz, 0);
        end
        return window_delta(lz, tz);
    endfunction

    function automatic bit stream_busy();
        return word_q.size() > 0 || s_valid || encoded_q.size() > 0;
    endfunction

    task automatic drain();
        while (stream_busy()) begin
            @(posedge aclk);
            #1;
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= stall_pct);
            if (!s_valid || in_taken) begin
                if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    s_valid   <= 1'b1;
                    s_word_in <= word_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (encoded_q.size() == 0) begin
                    $display("%0t: unexpected word hdr %h/%0d pay %h/%0d", $time,
                             m_header_code, m_header_len, m_payload, m_payload_len);
                    err_count++;
                end else begin
                    want = encoded_q.pop_front();
                    if (m_header_code !== want.header_code) begin
                        $display("%0t: header_code expected %h actual %h",
                                 $time, want.header_code, m_header_code);
                        err_count++;
                    end
                    if (m_header_len !== want.header_len) begin
                        $display("%0t: header_len expected %0d actual %0d",
                                 $time, want.header_len, m_header_len);
                        err_count++;
                    end
                    if (m_payload !== want.payload) begin
                        $display("%0t: payload expected %h actual %h",
                                 $time, want.payload, m_payload);
                        err_count++;
                    end
                    if (m_payload_len !== want.payload_len) begin
                        $display("%0t: payload_len expected %0d actual %0d",
                                 $time, want.payload_len, m_payload_len);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                encoded_q.push_back(encode_word(s_word_in));
            if ((s_valid && s_ready) || (m_valid && m_ready) || !stream_busy())
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: stalled with %0d words outstanding", $time, encoded_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_word_in = '0;
        m_ready   = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < 4; phase++) begin
            // sender holds off until every result is back
            drain();
            idle_pct  = idle_tab[phase];
            stall_pct = stall_tab[phase];
            if (phase == 0) begin
                push_word(64'h0);                            // raw first word
                push_word(gen_prev);                         // zero delta
                push_word(gen_prev ^ 64'hFFFF_FFFF_FFFF_FFFF); // full 64-bit window
                push_word(gen_prev);
                push_word(gen_prev ^ 64'h8000_0000_0000_0000); // len 1
                push_word(gen_prev ^ 64'h0000_0000_0000_0001); // lead capped
                push_word(gen_prev ^ 64'h00FF_0000_0000_0000); // reuse, capped lead
                push_word(gen_prev ^ 64'h0100_0000_0000_0000);
                push_word(gen_prev ^ 64'h8000_0000_0000_0001);
                push_word(gen_prev ^ 64'h4000_0000_0000_0002);
                push_word(gen_prev ^ 64'h4000_0000_0000_0004); // reuse, shifted
                push_word(gen_prev ^ 64'h4000_0000_0000_0002); // no reuse: tail below stored tail
                push_word(gen_prev ^ 64'h0000_0000_0000_F000);
                push_word(gen_prev);                         // stored tail 64
                push_word(gen_prev ^ 64'h0080_0000_0000_0000);
                push_word(gen_prev ^ 64'h0F00_0000_0000_0000);
                push_word(gen_prev ^ 64'h0FFF_F000_0000_0000); // len 16
                push_word(gen_prev ^ 64'h0FFF_F800_0000_0000); // len 17
                push_word(gen_prev ^ 64'hAAAA_AAAA_AAAA_AAAA);
                push_word(gen_prev ^ 64'hFFFF_FFFF_FFFF_FFFE);
                push_word(gen_prev ^ 64'h0000_0000_0000_0003);
                push_word(64'hFFFF_FFFF_FFFF_FFFF);
            end
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ($urandom_range(99) < 8)
                    push_word({$urandom, $urandom});
                else
                    push_word(gen_prev ^ random_delta());
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
